// ===== sv/msort_pkg.sv =====
// shared command and status types for the merge-insertion sort core
package msort_pkg;

  localparam int unsigned ValueW = 31;
  localparam int unsigned DataW  = 32;

  // controller to datapath commands
  typedef struct packed {
    logic load;       // take the request value, set insert position
    logic drop;       // mark a dropped request
    logic rd_prev;    // read chain entry below the insert position
    logic wr_value;   // write the new value at the insert position
    logic wr_shift;   // move the read entry up one place
    logic out_start;  // restart the output index
    logic out_read;   // read chain entry at the output index
    logic out_load;   // load the output register
    logic out_next;   // advance the output index
    logic clear;      // end of set
  } msort_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic full;       // store holds the maximum count
    logic pos_zero;   // insert position at the bottom
    logic greater;    // read entry is larger than the new value
    logic last_pend;  // the set is complete
    logic out_end;    // output index on the final entry
  } msort_stat_t;

endpackage

// ===== sv/msort_ctrl.sv =====
// controller state machine for load, insertion and output
module msort_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output msort_pkg::msort_cmd_t cmd,
  input  msort_pkg::msort_stat_t stat
);
  import msort_pkg::*;

  typedef enum logic [5:0] {
    IDLE     = 6'b000001,
    INS_RD   = 6'b000010,
    INS_CMP  = 6'b000100,
    OUT_RD   = 6'b001000,
    OUT_WAIT = 6'b010000,
    OUT_HOLD = 6'b100000
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == IDLE);
  assign m_tvalid = (state == OUT_HOLD);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      IDLE: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          if (stat.full) begin
            cmd.drop = 1'b1;
          end else begin
            state_next = INS_RD;
          end
        end
      end
      INS_RD: begin
        if (stat.pos_zero) begin
          cmd.wr_value = 1'b1;
          if (stat.last_pend) begin
            cmd.out_start = 1'b1;
            state_next = OUT_RD;
          end else begin
            state_next = IDLE;
          end
        end else begin
          cmd.rd_prev = 1'b1;
          state_next = INS_CMP;
        end
      end
      INS_CMP: begin
        if (stat.greater) begin
          cmd.wr_shift = 1'b1;
          state_next = INS_RD;
        end else begin
          cmd.wr_value = 1'b1;
          if (stat.last_pend) begin
            cmd.out_start = 1'b1;
            state_next = OUT_RD;
          end else begin
            state_next = IDLE;
          end
        end
      end
      OUT_RD: begin
        cmd.out_read = 1'b1;
        state_next = OUT_WAIT;
      end
      OUT_WAIT: begin
        cmd.out_load = 1'b1;
        state_next = OUT_HOLD;
      end
      OUT_HOLD: begin
        if (m_tready) begin
          if (stat.out_end) begin
            cmd.clear = 1'b1;
            state_next = IDLE;
          end else begin
            cmd.out_next = 1'b1;
            state_next = OUT_RD;
          end
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
    // a dropped request that closes the set goes straight to output
    if (state == IDLE && s_tvalid && stat.full && stat.last_pend) begin
      state_next = OUT_RD;
      cmd.out_start = 1'b1;
    end
  end

endmodule

// ===== sv/msort_datapath.sv =====
// sorted chain memory, insert position, counters and output register
module msort_datapath #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [msort_pkg::DataW-1:0] s_tdata,
  input  logic                   s_tlast,
  output logic [msort_pkg::DataW-1:0] m_tdata,
  output logic                   m_tlast,
  output logic                   m_tuser,
  input  msort_pkg::msort_cmd_t  cmd,
  output msort_pkg::msort_stat_t stat
);
  import msort_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  logic [ValueW-1:0] chain [MAX_ITEMS];
  logic [ValueW-1:0] rdata;
  logic [ValueW-1:0] new_val;
  logic [ValueW-1:0] out_val;
  logic [AW-1:0]     pos;
  logic [AW-1:0]     idx;
  logic [CW-1:0]     count;
  logic              dropped;
  logic              last_pend;
  logic              out_last;
  logic              out_ovf;
  logic              out_end;

  // chain memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_value) begin
      chain[pos] <= new_val;
    end else if (cmd.wr_shift) begin
      chain[pos] <= rdata;
    end
    if (cmd.rd_prev) begin
      rdata <= chain[pos - AW'(1)];
    end else if (cmd.out_read) begin
      rdata <= chain[idx];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      dropped   <= 1'b0;
      last_pend <= 1'b0;
    end else begin
      if (cmd.load) begin
        last_pend <= s_tlast;
        if (cmd.drop) begin
          dropped <= 1'b1;
        end else begin
          count <= count + CW'(1);
        end
      end
      if (cmd.clear) begin
        count     <= '0;
        dropped   <= 1'b0;
        last_pend <= 1'b0;
      end
    end
  end

  // insert position, output index and output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      new_val <= s_tdata[ValueW-1:0];
      pos     <= count[AW-1:0];
    end else if (cmd.wr_shift) begin
      pos <= pos - AW'(1);
    end
    if (cmd.out_start) begin
      idx <= '0;
    end else if (cmd.out_next) begin
      idx <= idx + AW'(1);
    end
    if (cmd.out_load) begin
      out_val  <= rdata;
      out_last <= out_end;
      out_ovf  <= dropped;
    end
  end

  assign out_end = ((CW'(idx) + CW'(1)) == count);

  assign stat.full      = (count == CW'(MAX_ITEMS));
  assign stat.pos_zero  = (pos == '0);
  assign stat.greater   = (rdata > new_val);
  assign stat.last_pend = cmd.load ? s_tlast : last_pend;
  assign stat.out_end   = out_last;

  assign m_tdata = {{(DataW - ValueW){1'b0}}, out_val};
  assign m_tlast = out_last;
  assign m_tuser = out_ovf;

endmodule

// ===== sv/merge_insertion_sort_core.sv =====
// top level of the sort core: controller and datapath
//
// channel  dir  tdata (low bit up)      tlast          tuser
// s_*      in   value[30:0], 0 pad      last of set    -
// m_*      out  value_res[30:0], 0 pad  last_res       overflow
//
// each value is inserted into the chain as it arrives: the entry below the
// insert position is read, then compared, and while it is larger than the
// new value it moves up one place (one memory port); the value is written
// above the first entry not larger, or at the bottom. a request that comes
// while the store is full is dropped. each result is read from the chain,
// loaded into the output register, then held on m_* until taken. rst is
// synchronous and empties the set; s_tready is low while sorting or emitting.
module merge_insertion_sort_core #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // value[30:0], zero[31]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // value_res[30:0], zero[31]
  output logic        m_tlast,
  output logic        m_tuser    // overflow
);
  import msort_pkg::*;

  msort_cmd_t  cmd;
  msort_stat_t stat;

  msort_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  msort_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser),
    .cmd     (cmd),
    .stat    (stat)
  );

endmodule
